### rtl/itoa_pkg.sv
// Shared constants and helpers for the integer to radix ASCII converter.
// Depends on nothing; imported by integer_to_radix_ascii.
package itoa_pkg;

   // Operand and text sizes
   localparam int VALUE_WIDTH = 32;
   localparam int MAX_CHARS   = 33;

   // Derived widths
   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
   localparam int IDX_W     = $clog2(MAX_CHARS);
   localparam int CNT_W     = $clog2(MAX_CHARS + 1);
   localparam int DIGIT_W   = 6;
   localparam int RADIX_W   = 6;
   localparam int CHAR_W    = 7;

   // Radix limits
   localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

   // Character codes
   localparam logic [CHAR_W-1:0]  CHAR_ZERO     = CHAR_W'(8'h30);
   localparam logic [CHAR_W-1:0]  CHAR_A        = CHAR_W'(8'h41);
   localparam logic [CHAR_W-1:0]  CHAR_MINUS    = CHAR_W'(8'h2D);
   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = DIGIT_W'(10);

   // Clamp a raw radix into the supported range
   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
      logic [RADIX_W-1:0] res;
      res = r;
      if (r < RADIX_MIN) begin
         res = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         res = RADIX_MAX;
      end
      return res;
   endfunction

   // Map a digit value to its ASCII character
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] res;
      if (d < DECIMAL_LIMIT) begin
         res = CHAR_ZERO + CHAR_W'(d);
      end else begin
         res = CHAR_A + CHAR_W'(d - DECIMAL_LIMIT);
      end
      return res;
   endfunction

endpackage

### rtl/integer_to_radix_ascii.sv
// Integer to radix ASCII converter: bit-serial restoring divider, digit store, character emitter.
// Depends on itoa_pkg for widths, character codes and the radix clamp.
// Sequence: digits are divided out after the start transfer until the quotient runs out, then
//   a minus sign for a negative value and each character (store read, output load) are emitted.
// Busy: high until the last character is strobed; a new item is accepted only while idle.
// Reset: synchronous, clears control state and the result strobe; the digit store is not cleared.
module integer_to_radix_ascii (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic signed [itoa_pkg::VALUE_WIDTH-1:0] req_value,
   input  logic [itoa_pkg::RADIX_W-1:0]          req_radix,
   output logic                                  rsp_valid,
   output logic [itoa_pkg::CHAR_W-1:0]           rsp_character,
   output logic                                  rsp_last
);
   import itoa_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DIVIDE = 5'b00010,
      ST_SIGN   = 5'b00100,
      ST_READ   = 5'b01000,
      ST_SHOW   = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   logic [VALUE_WIDTH-1:0]   mag_ff, mag_in;
   logic [DIGIT_W-1:0]       rem_ff, rem_in;
   logic [RADIX_W-1:0]       radix_ff, radix_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     neg_ff, neg_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]        rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Digit store and its registered read port
   logic [DIGIT_W-1:0]       digit_mem [MAX_CHARS];
   logic [DIGIT_W-1:0]       rd_data_ff;
   logic                     wr_en, rd_en;
   logic [IDX_W-1:0]         wr_idx, rd_idx;
   logic [DIGIT_W-1:0]       wr_data;

   // Divider datapath
   logic [DIGIT_W:0]         trial;
   logic [DIGIT_W:0]         radix_ext;
   logic                     q_bit;
   logic [DIGIT_W-1:0]       rem_step;
   logic [VALUE_WIDTH-1:0]   quot_step;
   logic                     last_step;
   logic                     room;
   logic [CNT_W-1:0]         count_dec;
   logic                     accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last  = rsp_last_ff;

   // One restoring division step: shift in the next dividend bit, subtract if it fits
   assign trial     = {rem_ff, mag_ff[VALUE_WIDTH-1]};
   assign radix_ext = {1'b0, radix_ff};
   assign q_bit     = (trial >= radix_ext);
   assign rem_step  = q_bit ? DIGIT_W'(trial - radix_ext) : DIGIT_W'(trial);
   assign quot_step = {mag_ff[VALUE_WIDTH-2:0], q_bit};
   assign last_step = (bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1));
   assign room      = (({1'b0, count_ff} + (CNT_W+1)'(neg_ff)) < (CNT_W+1)'(MAX_CHARS));
   assign count_dec = count_ff - CNT_W'(1);

   // Store write and read controls
   assign wr_en   = (state_ff == ST_DIVIDE) && last_step && room;
   assign wr_idx  = count_ff[IDX_W-1:0];
   assign wr_data = rem_step;
   assign rd_en   = (state_ff == ST_READ);
   assign rd_idx  = count_dec[IDX_W-1:0];

   // Next-state and datapath control
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      bit_cnt_in   = bit_cnt_ff;
      count_in     = count_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in     = req_value[VALUE_WIDTH-1];
               mag_in     = req_value[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - req_value[VALUE_WIDTH-1:0])
                                                     : req_value[VALUE_WIDTH-1:0];
               radix_in   = clamp_radix(req_radix);
               rem_in     = '0;
               bit_cnt_in = '0;
               count_in   = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            mag_in     = quot_step;
            rem_in     = rem_step;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (last_step) begin
               rem_in     = '0;
               bit_cnt_in = '0;
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end
               // Stop once the quotient runs out
               if (quot_step == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_READ;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_MINUS;
            rsp_last_in  = (count_ff == '0);
            state_in     = (count_ff == '0) ? ST_IDLE : ST_READ;
         end
         ST_READ: begin
            count_in = count_dec;
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = digit_to_char(rd_data_ff);
            rsp_last_in  = (count_ff == '0);
            state_in     = (count_ff == '0) ? ST_IDLE : ST_READ;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         count_ff     <= '0;
         neg_ff       <= 1'b0;
         mag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         count_ff     <= count_in;
         neg_ff       <= neg_in;
         mag_ff       <= mag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      radix_ff    <= radix_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Digit store write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         digit_mem[wr_idx] <= wr_data;
      end
   end

   // Digit store read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= digit_mem[rd_idx];
      end
   end

   // Checks
   a_accept_divides: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DIVIDE))
      else $error("accepted item did not start dividing");

   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < radix_ff))
      else $error("partial remainder not below radix");

   a_radix_clamped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> ((radix_ff >= RADIX_MIN) && (radix_ff <= RADIX_MAX)))
      else $error("radix out of range while dividing");

   a_show_strobes: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_SHOW) || (state_ff == ST_SIGN)) |=> rsp_valid_ff)
      else $error("character not strobed");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == ST_IDLE))
      else $error("last character while still converting");

endmodule
